FILE: design/keyboard_matrix_scanner_core_macros.svh
// ----------------------------------------------------------------------------
// keyboard matrix scanner assertion macros
// shared property forms for the port checker
// ----------------------------------------------------------------------------
`ifndef KEYBOARD_MATRIX_SCANNER_CORE_MACROS_SVH
`define KEYBOARD_MATRIX_SCANNER_CORE_MACROS_SVH

// same-cycle implication, idle while reset is high
`define KMS_ASSERT_SAME(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("kms assertion failed");

// next-cycle implication, idle while reset is high
`define KMS_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("kms assertion failed");

`endif

FILE: design/kms_pkg.sv
// ----------------------------------------------------------------------------
// kms_pkg
// code tables, field widths and event codes of the keyboard matrix scanner
// ----------------------------------------------------------------------------
package kms_pkg;

  localparam int TABLE_DIM    = 8;
  localparam int VTABLE_MAX   = 16;
  localparam int VIRTUAL_KEYS = 6;
  localparam int DEF_ROWS     = 8;
  localparam int DEF_COLS     = 8;

  localparam int CODE_W   = 10;
  localparam int VALUE_W  = 2;
  localparam int IDX_W    = 2;
  localparam int COLSEL_W = 3;
  localparam int ROWOUT_W = 8;
  localparam int IN_DATA_W  = 16;
  localparam int OUT_DATA_W = 16;

  // event kinds carried on tuser
  localparam logic ACT_KEY    = 1'b0;
  localparam logic ACT_SELECT = 1'b1;

  // key values
  localparam logic [VALUE_W-1:0] KEY_RELEASED = 2'd0;
  localparam logic [VALUE_W-1:0] KEY_PRESSED  = 2'd1;
  localparam logic [VALUE_W-1:0] KEY_REPEAT   = 2'd2;

  // select index that writes nothing
  localparam logic [IDX_W-1:0] SEL_IDX_NONE = 2'd3;

  typedef logic [CODE_W-1:0] code_t;

  typedef struct packed {
    code_t      code;
    logic [2:0] r1;
    logic [2:0] c1;
    logic [2:0] r2;
    logic [2:0] c2;
  } vkey_t;

  // host code per cell, zero marks an empty cell
  localparam code_t CELL_CODE [TABLE_DIM][TABLE_DIM] = '{
    '{10'd13, 10'd52, 10'd51, 10'd50, 10'd49, 10'd53, 10'd0, 10'd0},
    '{10'd57, 10'd38, 10'd37, 10'd36, 10'd35, 10'd39, 10'd0, 10'd0},
    '{10'd28, 10'd24, 10'd23, 10'd22, 10'd21, 10'd25, 10'd0, 10'd0},
    '{10'd0,  10'd10, 10'd9,  10'd8,  10'd7,  10'd11, 10'd0, 10'd0},
    '{10'd56, 10'd3,  10'd4,  10'd5,  10'd6,  10'd2,  10'd0, 10'd0},
    '{10'd42, 10'd31, 10'd32, 10'd33, 10'd34, 10'd30, 10'd0, 10'd0},
    '{10'd29, 10'd17, 10'd18, 10'd19, 10'd20, 10'd16, 10'd0, 10'd0},
    '{10'd0,  10'd45, 10'd46, 10'd47, 10'd48, 10'd44, 10'd0, 10'd0}
  };

  // virtual keys: two cells each (fnct plus a letter), code zero is unused
  localparam vkey_t VKEY_TABLE [VTABLE_MAX] = '{
    0:       '{10'd105, 3'd4, 3'd0, 3'd5, 3'd1},
    1:       '{10'd106, 3'd4, 3'd0, 3'd5, 3'd2},
    2:       '{10'd103, 3'd4, 3'd0, 3'd6, 3'd2},
    3:       '{10'd108, 3'd4, 3'd0, 3'd7, 3'd1},
    4:       '{10'd110, 3'd4, 3'd0, 3'd4, 3'd1},
    5:       '{10'd111, 3'd4, 3'd0, 3'd4, 3'd5},
    default: '{10'd0,   3'd0, 3'd0, 3'd0, 3'd0}
  };

endpackage

FILE: design/keyboard_matrix_scanner_core.sv
// ----------------------------------------------------------------------------
// keyboard_matrix_scanner_core
// 8x8 key matrix driven by host key events and column select writes
// ----------------------------------------------------------------------------
// usage:
//   s_* takes one event beat per cycle while s_tready is high. s_tuser picks
//   the kind: key event (host code plus released/pressed/autorepeat) or a
//   write of one column select bit. every event gives exactly one m_* beat:
//   the active-low row lines of the selected column after the event, the
//   column select value, and on m_tuser a flag for a press or release whose
//   nonzero code matched no table entry. an event passes through the input
//   register, then the result register; the matrix update and row read sit
//   between them, so one beat per cycle is sustained while m_tready is high.
//   a stalled m_tready holds the result register; one more event can wait
//   in the input register, after that s_tready drops until m_tready returns.
//   rst (synchronous, active high) releases every key, clears the column
//   select and empties both registers.
// ----------------------------------------------------------------------------
module keyboard_matrix_scanner_core
  import kms_pkg::*;
#(
  parameter int MATRIX_ROWS = DEF_ROWS,
  parameter int MATRIX_COLS = DEF_COLS
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  s_tvalid,
  output logic                  s_tready,
  // key_code[9:0], key_value[11:10], select_bit_index[13:12],
  // select_bit_value[14], zero[15]
  input  logic [IN_DATA_W-1:0]  s_tdata,
  // action[0]
  input  logic                  s_tuser,
  output logic                  m_tvalid,
  input  logic                  m_tready,
  // row_lines[7:0], selected_column[10:8], zero[15:11]
  output logic [OUT_DATA_W-1:0] m_tdata,
  // unmapped_key[0]
  output logic                  m_tuser
);

  localparam int CELLS = MATRIX_ROWS * MATRIX_COLS;

  // input register
  logic                s1_valid;
  logic                s1_action;
  code_t               s1_code;
  logic [VALUE_W-1:0]  s1_value;
  logic [IDX_W-1:0]    s1_idx;
  logic                s1_bitv;

  // matrix state
  logic [CELLS-1:0]    key_pressed;
  logic [CELLS-1:0]    key_pressed_next;
  logic [COLSEL_W-1:0] column_select;
  logic [COLSEL_W-1:0] column_select_next;

  logic advance;
  logic key_evt;
  logic [TABLE_DIM*TABLE_DIM-1:0] cell_hit;
  logic [TABLE_DIM*TABLE_DIM-1:0] vkey_set;
  logic [TABLE_DIM*TABLE_DIM-1:0] set_mask;
  logic vkey_hit;
  logic unmapped_next;
  logic [ROWOUT_W-1:0] row_lines_next;

  // result register moves when empty or taken; input register moves with it
  assign advance  = !m_tvalid || m_tready;
  assign s_tready = !s1_valid || advance;

  // press and release only, code zero matches nothing
  assign key_evt = (s1_action == ACT_KEY) && (s1_value == KEY_RELEASED ||
                   s1_value == KEY_PRESSED) && (s1_code != '0);

  // direct table: every cell holding the code
  for (genvar r = 0; r < TABLE_DIM; r++) begin : g_trow
    for (genvar c = 0; c < TABLE_DIM; c++) begin : g_tcol
      assign cell_hit[r*TABLE_DIM+c] = (CELL_CODE[r][c] == s1_code);
    end
  end

  // virtual keys, searched only when the direct table misses
  always_comb begin
    vkey_set = '0;
    vkey_hit = 1'b0;
    for (int i = 0; i < VIRTUAL_KEYS; i++) begin
      if (VKEY_TABLE[i].code == s1_code) begin
        vkey_hit = 1'b1;
        vkey_set[{VKEY_TABLE[i].r1, VKEY_TABLE[i].c1}] = 1'b1;
        vkey_set[{VKEY_TABLE[i].r2, VKEY_TABLE[i].c2}] = 1'b1;
      end
    end
  end

  always_comb begin
    set_mask      = '0;
    unmapped_next = 1'b0;
    if (key_evt) begin
      if (|cell_hit) begin
        set_mask = cell_hit;
      end else begin
        set_mask      = vkey_set;
        unmapped_next = !vkey_hit;
      end
    end
  end

  // table cells outside the matrix are dropped, extra matrix cells never change
  for (genvar r = 0; r < MATRIX_ROWS; r++) begin : g_srow
    for (genvar c = 0; c < MATRIX_COLS; c++) begin : g_scol
      if (r < TABLE_DIM && c < TABLE_DIM) begin : g_mapped
        assign key_pressed_next[r*MATRIX_COLS+c] = set_mask[r*TABLE_DIM+c] ?
          s1_value[0] : key_pressed[r*MATRIX_COLS+c];
      end else begin : g_fixed
        assign key_pressed_next[r*MATRIX_COLS+c] = key_pressed[r*MATRIX_COLS+c];
      end
    end
  end

  // one select bit per event, index three writes nothing
  always_comb begin
    column_select_next = column_select;
    if (s1_action == ACT_SELECT && s1_idx != SEL_IDX_NONE) begin
      column_select_next[s1_idx] = s1_bitv;
    end
  end

  // column mux on the updated matrix; rows or columns outside read released
  for (genvar r = 0; r < ROWOUT_W; r++) begin : g_read
    if (r < MATRIX_ROWS) begin : g_live
      logic row_down;
      always_comb begin
        row_down = 1'b0;
        for (int c = 0; c < MATRIX_COLS; c++) begin
          if (int'(column_select_next) == c) begin
            row_down = key_pressed_next[r*MATRIX_COLS+c];
          end
        end
      end
      assign row_lines_next[r] = !row_down;
    end else begin : g_none
      assign row_lines_next[r] = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid      <= 1'b0;
      m_tvalid      <= 1'b0;
      key_pressed   <= '0;
      column_select <= '0;
    end else begin
      if (s_tready) begin
        s1_valid <= s_tvalid;
      end
      if (advance) begin
        m_tvalid <= s1_valid;
      end
      if (s1_valid && advance) begin
        key_pressed   <= key_pressed_next;
        column_select <= column_select_next;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      s1_action <= s_tuser;
      s1_code   <= s_tdata[CODE_W-1:0];
      s1_value  <= s_tdata[CODE_W+VALUE_W-1:CODE_W];
      s1_idx    <= s_tdata[CODE_W+VALUE_W+IDX_W-1:CODE_W+VALUE_W];
      s1_bitv   <= s_tdata[CODE_W+VALUE_W+IDX_W];
    end
    if (s1_valid && advance) begin
      m_tdata <= {(OUT_DATA_W-ROWOUT_W-COLSEL_W)'(0), column_select_next,
                  row_lines_next};
      m_tuser <= unmapped_next;
    end
  end

endmodule

FILE: design/kms_checker.sv
// ----------------------------------------------------------------------------
// kms_checker
// port-level checks of the keyboard matrix scanner, bound to the top level
// ----------------------------------------------------------------------------
`include "keyboard_matrix_scanner_core_macros.svh"

module kms_checker
  import kms_pkg::*;
#(
  parameter int MATRIX_COLS = DEF_COLS
) (
  input logic                  clk,
  input logic                  rst,
  input logic                  s_tready,
  input logic                  m_tvalid,
  input logic                  m_tready,
  input logic [OUT_DATA_W-1:0] m_tdata,
  input logic                  m_tuser
);

  // stalled result beat holds
  `KMS_ASSERT_NEXT(a_out_hold, m_tvalid && !m_tready,
    m_tvalid && $stable(m_tdata) && $stable(m_tuser))

  // a free output side never blocks the input
  `KMS_ASSERT_SAME(a_ready_when_drained, m_tready || !m_tvalid, s_tready)

  // padding above the column select stays zero
  `KMS_ASSERT_SAME(a_pad_zero, m_tvalid,
    m_tdata[OUT_DATA_W-1:ROWOUT_W+COLSEL_W] == '0)

  // a column beyond the matrix reads all released
  `KMS_ASSERT_SAME(a_col_outside, m_tvalid &&
    int'(m_tdata[ROWOUT_W+COLSEL_W-1:ROWOUT_W]) >= MATRIX_COLS,
    m_tdata[ROWOUT_W-1:0] == '1)

endmodule

bind keyboard_matrix_scanner_core kms_checker #(
  .MATRIX_COLS (MATRIX_COLS)
) u_kms_checker (
  .clk      (clk),
  .rst      (rst),
  .s_tready (s_tready),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata),
  .m_tuser  (m_tuser)
);

FILE: bench/kms_scan_checker.sv
// ----------------------------------------------------------------------------
// kms_scan_checker
// watches both streams of the keyboard matrix scanner, keeps its own copy of
// the key matrix and column select, and compares every result beat in order
// ----------------------------------------------------------------------------
module kms_scan_checker
  import kms_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  s_tvalid,
  input  logic                  s_tready,
  input  logic [IN_DATA_W-1:0]  s_tdata,
  input  logic                  s_tuser,
  input  logic                  m_tvalid,
  input  logic                  m_tready,
  input  logic [OUT_DATA_W-1:0] m_tdata,
  input  logic                  m_tuser,
  output int                    fail_count,
  output int                    pending
);

  typedef struct packed {
    logic [ROWOUT_W-1:0] row_lines;
    logic [COLSEL_W-1:0] selected_column;
    logic                unmapped_key;
  } scan_t;

  // pressed bits held per column, bit r is row r
  logic [DEF_ROWS-1:0] col_keys [DEF_COLS];
  logic [COLSEL_W-1:0] col_sel;
  scan_t               scan_expected [$];
  int                  mismatches = 0;

  // applies one event to the matrix copy and gives the scan seen after it
  task automatic apply_event(input logic act, input code_t code,
                             input logic [VALUE_W-1:0] val,
                             input logic [IDX_W-1:0] idx, input logic bitv,
                             output scan_t res);
    int   r;
    int   c;
    int   i;
    logic hit;
    hit = 1'b0;
    res.unmapped_key = 1'b0;
    if (act == ACT_KEY) begin
      if ((val == KEY_PRESSED || val == KEY_RELEASED) && code != '0) begin
        for (r = 0; r < TABLE_DIM; r++)
          for (c = 0; c < TABLE_DIM; c++)
            if (CELL_CODE[r][c] != '0 && CELL_CODE[r][c] == code) begin
              col_keys[c][r] = val[0];
              hit = 1'b1;
            end
        if (!hit) begin
          for (i = 0; i < VIRTUAL_KEYS && i < VTABLE_MAX; i++)
            if (VKEY_TABLE[i].code != '0 && VKEY_TABLE[i].code == code) begin
              col_keys[VKEY_TABLE[i].c1][VKEY_TABLE[i].r1] = val[0];
              col_keys[VKEY_TABLE[i].c2][VKEY_TABLE[i].r2] = val[0];
              hit = 1'b1;
            end
        end
        res.unmapped_key = !hit;
      end
    end else if (idx != SEL_IDX_NONE) begin
      col_sel[idx] = bitv;
    end
    res.selected_column = col_sel;
    res.row_lines = (col_sel < DEF_COLS) ? ~col_keys[col_sel] : '1;
  endtask

  always @(posedge clk) begin
    scan_t got;
    scan_t want;
    if (rst) begin
      foreach (col_keys[c]) col_keys[c] = '0;
      col_sel = '0;
      scan_expected.delete();
    end else begin
      if (m_tvalid && m_tready) begin
        got = '{row_lines: m_tdata[ROWOUT_W-1:0],
                selected_column: m_tdata[ROWOUT_W +: COLSEL_W],
                unmapped_key: m_tuser};
        if (scan_expected.size() == 0) begin
          $error("result beat with no expectation waiting");
          mismatches++;
        end else begin
          want = scan_expected.pop_front();
          if (got.row_lines !== want.row_lines) begin
            $error("row_lines: expected %02h, actual %02h", want.row_lines, got.row_lines);
            mismatches++;
          end
          if (got.selected_column !== want.selected_column) begin
            $error("selected_column: expected %0d, actual %0d",
                   want.selected_column, got.selected_column);
            mismatches++;
          end
          if (got.unmapped_key !== want.unmapped_key) begin
            $error("unmapped_key: expected %0b, actual %0b",
                   want.unmapped_key, got.unmapped_key);
            mismatches++;
          end
        end
      end
      if (s_tvalid && s_tready) begin
        apply_event(s_tuser, s_tdata[CODE_W-1:0], s_tdata[CODE_W +: VALUE_W],
                    s_tdata[CODE_W+VALUE_W +: IDX_W], s_tdata[CODE_W+VALUE_W+IDX_W],
                    want);
        scan_expected.push_back(want);
      end
    end
    fail_count <= mismatches;
    pending    <= scan_expected.size();
  end

endmodule

FILE: bench/testbench.sv
// ----------------------------------------------------------------------------
// testbench
// drives key and column select events into the keyboard matrix scanner with
// bursty input and a stalling output, and reports the checker's verdict
// ----------------------------------------------------------------------------
module testbench;
  import kms_pkg::*;

  // key value that the block treats like autorepeat
  localparam logic [VALUE_W-1:0] KEY_UNUSED = 2'd3;
  localparam int RANDOM_BEATS = 1750;
  localparam int DRAIN_LIMIT  = 5000;

  logic                  clk = 1'b0;
  logic                  rst = 1'b1;
  logic                  s_tvalid = 1'b0;
  logic                  s_tready;
  // key_code[9:0], key_value[11:10], select_bit_index[13:12],
  // select_bit_value[14], zero[15]
  logic [IN_DATA_W-1:0]  s_tdata = '0;
  // action[0]
  logic                  s_tuser = 1'b0;
  logic                  m_tvalid;
  logic                  m_tready = 1'b0;
  // row_lines[7:0], selected_column[10:8], zero[15:11]
  logic [OUT_DATA_W-1:0] m_tdata;
  // unmapped_key[0]
  logic                  m_tuser;
  int                    fail_count;
  int                    pending;
  int                    ready_tick = 0;

  initial begin
    forever #5 clk = ~clk;
  end

  keyboard_matrix_scanner_core i_dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
  );

  kms_scan_checker i_checker (
    .clk        (clk),
    .rst        (rst),
    .s_tvalid   (s_tvalid),
    .s_tready   (s_tready),
    .s_tdata    (s_tdata),
    .s_tuser    (s_tuser),
    .m_tvalid   (m_tvalid),
    .m_tready   (m_tready),
    .m_tdata    (m_tdata),
    .m_tuser    (m_tuser),
    .fail_count (fail_count),
    .pending    (pending)
  );

  // receiver stall pattern: rotates through always ready, coin flip,
  // mostly stalled and a periodic one-in-five stall
  always @(negedge clk) begin
    int phase;
    ready_tick <= ready_tick + 1;
    phase = (ready_tick / 97) % 4;
    if (phase == 0) begin
      m_tready <= 1'b1;
    end else if (phase == 1) begin
      m_tready <= 1'($urandom_range(0, 1));
    end else if (phase == 2) begin
      m_tready <= ($urandom_range(0, 3) == 0);
    end else begin
      m_tready <= (ready_tick % 5 != 0);
    end
  end

  // present one beat at the falling edge and hold it until accepted;
  // valid stays high so back-to-back beats need no extra edge
  task automatic send_beat(input logic act, input code_t code,
                           input logic [VALUE_W-1:0] val,
                           input logic [IDX_W-1:0] idx, input logic bitv);
    @(negedge clk);
    s_tuser  <= act;
    s_tdata  <= {1'b0, bitv, idx, val, code};
    s_tvalid <= 1'b1;
    do @(posedge clk); while (!s_tready);
  endtask

  // key event, the select fields carry random junk
  task automatic key_beat(input code_t code, input logic [VALUE_W-1:0] val);
    send_beat(ACT_KEY, code, val, IDX_W'($urandom_range(0, 3)),
              1'($urandom_range(0, 1)));
  endtask

  // column select write, the key fields carry random junk
  task automatic select_beat(input logic [IDX_W-1:0] idx, input logic bitv);
    send_beat(ACT_SELECT, CODE_W'($urandom_range(0, 1023)),
              VALUE_W'($urandom_range(0, 3)), idx, bitv);
  endtask

  // drop valid for a number of cycles
  task automatic idle_gap(input int cycles);
    if (cycles > 0) begin
      @(negedge clk);
      s_tvalid <= 1'b0;
      repeat (cycles - 1) @(negedge clk);
    end
  endtask

  // a code that hits either a matrix cell or a virtual key
  function automatic code_t mapped_code();
    code_t cd;
    int    k;
    cd = '0;
    while (cd == '0) begin
      k = $urandom_range(0, 63 + VIRTUAL_KEYS);
      if (k < 64) begin
        cd = CELL_CODE[k / 8][k % 8];
      end else begin
        cd = VKEY_TABLE[k - 64].code;
      end
    end
    return cd;
  endfunction

  // mostly press and release, now and then autorepeat or the unused value
  function automatic logic [VALUE_W-1:0] random_value();
    int v;
    v = $urandom_range(0, 19);
    if (v < 9) return KEY_PRESSED;
    if (v < 18) return KEY_RELEASED;
    if (v == 18) return KEY_REPEAT;
    return KEY_UNUSED;
  endfunction

  task automatic random_beat();
    int k;
    k = $urandom_range(0, 99);
    if (k < 62) begin
      key_beat(mapped_code(), random_value());
    end else if (k < 82) begin
      if ($urandom_range(0, 15) == 0) begin
        select_beat(SEL_IDX_NONE, 1'($urandom_range(0, 1)));
      end else begin
        select_beat(IDX_W'($urandom_range(0, 2)), 1'($urandom_range(0, 1)));
      end
    end else if (k < 85) begin
      key_beat('0, random_value());
    end else begin
      // noise over codes 0 to 767, mostly unmapped
      key_beat(CODE_W'($urandom_range(0, 767)), VALUE_W'($urandom_range(0, 3)));
    end
  endtask

  initial begin
    int sent;
    int burst;
    int waited;
    repeat (8) @(negedge clk);
    rst <= 1'b0;
    idle_gap(2);

    // directed: plain cells, virtual keys, ignored values and codes
    key_beat(10'd13, KEY_PRESSED);        // row 0 column 0
    key_beat(10'd13, KEY_RELEASED);
    key_beat(10'd105, KEY_PRESSED);       // fnct plus letter, two cells
    select_beat(2'd0, 1'b1);              // column 1 shows the second cell
    key_beat(10'd105, KEY_REPEAT);        // autorepeat changes nothing
    key_beat(10'd52, KEY_UNUSED);         // unused value changes nothing
    key_beat(10'd0, KEY_PRESSED);         // code zero never hits empty cells
    key_beat(10'd767, KEY_PRESSED);       // top of the noise range, unmapped
    key_beat(10'd512, KEY_RELEASED);      // unmapped release
    select_beat(SEL_IDX_NONE, 1'b1);      // bad index writes nothing
    key_beat(10'd45, KEY_PRESSED);        // bottom row, column 1
    select_beat(2'd1, 1'b1);
    select_beat(2'd2, 1'b1);              // column 7, always empty
    key_beat(10'd105, KEY_RELEASED);
    key_beat(10'd111, KEY_PRESSED);       // shares the fnct cell
    select_beat(2'd1, 1'b0);              // column 5
    key_beat(10'd108, KEY_PRESSED);
    select_beat(2'd0, 1'b0);              // column 4
    key_beat(10'd48, KEY_PRESSED);
    key_beat(10'd111, KEY_RELEASED);
    select_beat(2'd2, 1'b0);              // back to column 0
    key_beat(10'd108, KEY_RELEASED);
    key_beat(10'd48, KEY_RELEASED);
    key_beat(10'd45, KEY_RELEASED);

    // random part: bursts with gaps, every third stretch runs gap free
    sent = 0;
    while (sent < RANDOM_BEATS) begin
      burst = $urandom_range(1, 24);
      for (int j = 0; j < burst && sent < RANDOM_BEATS; j++) begin
        random_beat();
        sent++;
      end
      if ((sent / 200) % 3 != 0) idle_gap($urandom_range(0, 6));
    end
    idle_gap(1);

    // let the last results drain, then let the pipeline settle before the verdict
    waited = 0;
    while (pending != 0 && waited < DRAIN_LIMIT) begin
      @(posedge clk);
      waited++;
    end
    repeat (8) @(posedge clk);
    if (pending != 0) $error("%0d expected results never arrived", pending);
    if (fail_count == 0 && pending == 0) begin
      $display("testbench passed");
    end else begin
      $display("testbench failed");
    end
    $finish;
  end

  // hard stop well beyond the slowest legal run
  initial begin
    #3000000;
    $display("testbench failed");
    $finish;
  end

endmodule

FILE: keyboard_matrix_scanner_core.f
+incdir+design
design/kms_pkg.sv
design/keyboard_matrix_scanner_core.sv
design/kms_checker.sv
bench/kms_scan_checker.sv
bench/testbench.sv
